// ===== rtl/lph_pkg.sv =====
package lph_pkg;

  localparam int INDEX_BITS = 10;
  localparam int SLOTS      = 1 << INDEX_BITS;
  localparam int CNT_W      = INDEX_BITS + 1;
  localparam int KEY_W      = 60;
  localparam int DATA_W     = 64;
  localparam logic [63:0] FIB_MULT = 64'h9E37_79B9_7F4A_7C15;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_REMOVED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_INVALID   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_SHIFT,
    S_SH_HASH,
    S_DEL,
    S_RESP
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  entry_addr;
    logic [DATA_W-1:0]  entry_size;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  found_addr;
    logic [DATA_W-1:0]  found_size;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  addr;
    logic [DATA_W-1:0]  size;
  } row_t;

  typedef struct packed {
    logic                   done;
    logic [INDEX_BITS-1:0]  home;
  } hash_res_t;

endpackage

// ===== rtl/lph_hash.sv =====
module lph_hash (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lph_pkg::KEY_W-1:0] key,
  output lph_pkg::hash_res_t        res
);
  import lph_pkg::*;

  // 64-bit Fibonacci product mod 2^64 from three 32x32 partial products
  logic [KEY_W-1:0]       key_r;
  logic [1:0]             cnt_r;
  logic                   run_r;
  logic                   done_r;
  logic [63:0]            prod_r;
  logic [63:0]            acc_r;
  logic [INDEX_BITS-1:0]  home_r;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            acc_sum;

  always_comb begin
    case (cnt_r)
      2'd0: begin
        mul_a = key_r[31:0];
        mul_b = FIB_MULT[31:0];
      end
      2'd1: begin
        mul_a = key_r[31:0];
        mul_b = FIB_MULT[63:32];
      end
      default: begin
        mul_a = 32'(key_r[KEY_W-1:32]);
        mul_b = FIB_MULT[31:0];
      end
    endcase
  end

  always_comb begin
    case (cnt_r)
      2'd1:    acc_sum = prod_r;
      default: acc_sum = acc_r + {prod_r[31:0], 32'h0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= run_r && (cnt_r == 2'd3);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    prod_r <= mul_a * mul_b;
    if (run_r && (cnt_r != 2'd0)) begin
      acc_r <= acc_sum;
    end
    if (run_r && (cnt_r == 2'd3)) begin
      home_r <= acc_sum[63 -: INDEX_BITS];
    end
  end

  assign res.done = done_r;
  assign res.home = home_r;

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// Open-addressing hash map (linear probing, backward-shift delete) over 1024
// slots held in one single-port-read synchronous RAM row {key, addr, size}.
// After reset the block clears the table, one slot per cycle, with in_stall
// high. One request is processed at a time: a zero key or an insert into a
// full table answers without hashing; otherwise the key is hashed by a shared
// 32x32 multiplier, then the probe walks one slot per cycle. A remove that
// hits then walks the chain behind the hole, with a RAM read plus a rehash of
// the slot key for each slot, and then clears the final hole. The result
// waits in an output register while the next request runs.
module linear_probe_hash_map (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lph_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lph_pkg::out_t out_data
);
  import lph_pkg::*;

  state_t                 state_r, state_nxt;
  in_t                    req_r, req_nxt;
  out_t                   res_r, res_nxt;
  out_t                   out_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0]  idx_r, idx_nxt;
  logic [INDEX_BITS-1:0]  j_r, j_nxt;
  logic [INDEX_BITS-1:0]  n_r, n_nxt;
  logic [INDEX_BITS-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  row_t                   row_r, row_nxt;

  // table RAM
  row_t                   mem [SLOTS];
  row_t                   mem_q;
  row_t                   fwd_row_r;
  logic                   fwd_r;
  logic                   we;
  logic [INDEX_BITS-1:0]  wa;
  logic [INDEX_BITS-1:0]  ra;
  row_t                   wd;
  row_t                   rd_row;

  logic                   hash_start;
  logic [KEY_W-1:0]       hash_key;
  hash_res_t              hash_res;

  logic                   load_out;
  logic                   out_free;
  logic                   rd_empty;
  logic                   rd_hit;
  logic                   probe_last;
  logic                   movable;
  logic [INDEX_BITS-1:0]  idx_inc;
  logic [INDEX_BITS-1:0]  j_inc;
  logic [INDEX_BITS-1:0]  hole_next;

  lph_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .res   (hash_res)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q     <= mem[ra];
    fwd_r     <= we && (wa == ra);
    fwd_row_r <= wd;
  end

  assign rd_row     = fwd_r ? fwd_row_r : mem_q;
  assign rd_empty   = (rd_row.key == '0);
  assign rd_hit     = (rd_row.key == req_r.key);
  assign probe_last = (n_r == '1);
  assign idx_inc    = idx_r + INDEX_BITS'(1);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    if (idx_r < j_r) begin
      movable = (hash_res.home <= idx_r) || (hash_res.home > j_r);
    end else begin
      movable = (hash_res.home <= idx_r) && (hash_res.home > j_r);
    end
  end

  assign hole_next = movable ? j_r : idx_r;
  assign j_inc     = j_r + INDEX_BITS'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if ((in_data.key == '0) ||
              ((in_data.func == FUNC_INSERT) && (used_r >= CNT_W'(SLOTS)))) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_res.done) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (req_r.func == FUNC_INSERT) begin
          if (rd_empty) begin
            state_nxt = S_RESP;
          end
        end else if (rd_hit) begin
          state_nxt = S_SHIFT;
        end else if (rd_empty || probe_last) begin
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        state_nxt = rd_empty ? S_DEL : S_SH_HASH;
      end
      S_SH_HASH: begin
        if (hash_res.done) begin
          state_nxt = (j_inc == hole_next) ? S_DEL : S_SHIFT;
        end
      end
      S_DEL: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and RAM control
  always_comb begin
    req_nxt    = req_r;
    res_nxt    = res_r;
    idx_nxt    = idx_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    clr_nxt    = clr_r;
    used_nxt   = used_r;
    row_nxt    = row_r;
    we         = 1'b0;
    wa         = idx_r;
    wd         = '0;
    ra         = idx_r;
    hash_start = 1'b0;
    hash_key   = req_r.key;
    load_out   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        clr_nxt = clr_r + INDEX_BITS'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          res_nxt = '{status: STAT_FULL, found_addr: '0, found_size: '0};
          if (in_data.key == '0) begin
            res_nxt.status = STAT_INVALID;
          end else if (!((in_data.func == FUNC_INSERT) &&
                         (used_r >= CNT_W'(SLOTS)))) begin
            hash_start = 1'b1;
            hash_key   = in_data.key;
          end
        end
      end
      S_HASH: begin
        if (hash_res.done) begin
          idx_nxt = hash_res.home;
          n_nxt   = '0;
          ra      = hash_res.home;
        end
      end
      S_PROBE: begin
        if (req_r.func == FUNC_INSERT) begin
          if (rd_empty) begin
            we             = 1'b1;
            wd             = '{key: req_r.key, addr: req_r.entry_addr,
                               size: req_r.entry_size};
            used_nxt       = used_r + CNT_W'(1);
            res_nxt.status = STAT_INSERTED;
          end else begin
            idx_nxt = idx_inc;
            ra      = idx_inc;
          end
        end else if (rd_hit) begin
          res_nxt = '{status: STAT_REMOVED, found_addr: rd_row.addr,
                      found_size: rd_row.size};
          j_nxt   = idx_inc;
          ra      = idx_inc;
        end else if (rd_empty || probe_last) begin
          res_nxt.status = STAT_NOT_FOUND;
        end else begin
          idx_nxt = idx_inc;
          n_nxt   = n_r + INDEX_BITS'(1);
          ra      = idx_inc;
        end
      end
      S_SHIFT: begin
        if (!rd_empty) begin
          row_nxt    = rd_row;
          hash_start = 1'b1;
          hash_key   = rd_row.key;
        end
      end
      S_SH_HASH: begin
        if (hash_res.done) begin
          if (movable) begin
            we = 1'b1;
            wd = row_r;
          end
          idx_nxt = hole_next;
          j_nxt   = j_inc;
          ra      = j_inc;
        end
      end
      S_DEL: begin
        we = 1'b1;
        if (used_r != '0) begin
          used_nxt = used_r - CNT_W'(1);
        end
      end
      S_RESP: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    idx_r <= idx_nxt;
    j_r   <= j_nxt;
    n_r   <= n_nxt;
    row_r <= row_nxt;
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== test/linear_probe_hash_map_test.sv =====
module linear_probe_hash_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lph_pkg::*;

  localparam int QUIET_LIMIT  = 50000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 150;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  linear_probe_hash_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Mirror of the table contents.
  logic [KEY_W-1:0]  map_keys  [SLOTS];
  logic [DATA_W-1:0] map_addrs [SLOTS];
  logic [DATA_W-1:0] map_sizes [SLOTS];
  int                map_used;

  logic [KEY_W-1:0]  stored_keys[$];
  out_t              replies_due[$];
  int                mismatches = 0;
  bit                no_idle = 1'b0;
  int                hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] r;
    r = '0;
    while (r[KEY_W-1:0] == '0) r = {$urandom(), $urandom()};
    return r[KEY_W-1:0];
  endfunction

  function automatic int home_of(logic [KEY_W-1:0] k);
    logic [63:0] prod;
    prod = {{(64-KEY_W){1'b0}}, k};
    prod = prod * FIB_MULT;
    return int'(prod[63 -: INDEX_BITS]);
  endfunction

  // Random key whose home slot lies in [lo, lo+span), wrapping.
  function automatic logic [KEY_W-1:0] key_homed_in(int lo, int span);
    logic [KEY_W-1:0] k;
    k = random_key();
    while (((home_of(k) - lo + SLOTS) % SLOTS) >= span) k = random_key();
    return k;
  endfunction

  task automatic apply_to_map(input in_t req);
    out_t reply;
    int   slot, probe, steps, h, idx;
    bit   hit, stop, movable;
    reply = '0;
    if (req.key == '0) begin
      reply.status = STAT_INVALID;
    end else if (req.func == FUNC_INSERT) begin
      if (map_used >= SLOTS) begin
        reply.status = STAT_FULL;
      end else begin
        slot = home_of(req.key);
        while (map_keys[slot] != '0) slot = (slot + 1) % SLOTS;
        map_keys[slot]  = req.key;
        map_addrs[slot] = req.entry_addr;
        map_sizes[slot] = req.entry_size;
        map_used++;
        stored_keys.push_back(req.key);
        reply.status = STAT_INSERTED;
      end
    end else begin
      slot  = home_of(req.key);
      hit   = 1'b0;
      stop  = 1'b0;
      steps = 0;
      while (!stop && steps < SLOTS) begin
        if (map_keys[slot] == req.key) begin
          hit  = 1'b1;
          stop = 1'b1;
        end else if (map_keys[slot] == '0) begin
          stop = 1'b1;
        end else begin
          slot = (slot + 1) % SLOTS;
          steps++;
        end
      end
      if (!hit) begin
        reply.status = STAT_NOT_FOUND;
      end else begin
        reply.status     = STAT_REMOVED;
        reply.found_addr = map_addrs[slot];
        reply.found_size = map_sizes[slot];
        idx = 0;
        while (idx < stored_keys.size() && stored_keys[idx] != req.key) idx++;
        if (idx < stored_keys.size()) stored_keys.delete(idx);
        // backward shift into the hole
        probe = slot;
        stop  = 1'b0;
        while (!stop) begin
          probe = (probe + 1) % SLOTS;
          if (probe == slot || map_keys[probe] == '0) begin
            stop = 1'b1;
          end else begin
            h = home_of(map_keys[probe]);
            if (slot < probe) movable = (h <= slot || h > probe);
            else              movable = (h <= slot && h > probe);
            if (movable) begin
              map_keys[slot]  = map_keys[probe];
              map_addrs[slot] = map_addrs[probe];
              map_sizes[slot] = map_sizes[probe];
              slot = probe;
            end
          end
        end
        map_keys[slot] = '0;
        map_used--;
      end
    end
    replies_due.push_back(reply);
  endtask

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_request(input func_t f, input logic [KEY_W-1:0] k,
                              input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] s);
    in_t req;
    int  gap;
    req.func       = f;
    req.key        = k;
    req.entry_addr = a;
    req.entry_size = s;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_to_map(req);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: result with none expected: status %0d addr %h size %h",
               $time, got.status, got.found_addr, got.found_size);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      mismatches++;
    end
    if (got.found_addr !== want.found_addr) begin
      $display("%0t: found_addr expected %h actual %h", $time, want.found_addr,
               got.found_addr);
      mismatches++;
    end
    if (got.found_size !== want.found_size) begin
      $display("%0t: found_size expected %h actual %h", $time, want.found_size,
               got.found_size);
      mismatches++;
    end
  endtask

  // Result side: stall each reply for a drawn number of valid cycles.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      check_result(out_data);
      hold_left = draw_gap();
    end else if (out_valid && hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left > 0);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("linear_probe_hash_map_test: errors");
    $finish;
  end

  task automatic test_empty_and_invalid();
    send_request(FUNC_REMOVE, 60'd1, rand64(), rand64());
    send_request(FUNC_INSERT, '0, '1, '1);
    send_request(FUNC_REMOVE, '0, '0, '0);
    send_request(FUNC_INSERT, 60'd1, '0, '0);
    send_request(FUNC_REMOVE, 60'd1, '1, '1);
  endtask

  task automatic test_duplicates();
    send_request(FUNC_INSERT, '1, '1, '1);
    send_request(FUNC_INSERT, '1, 64'd5, 64'd6);
    send_request(FUNC_REMOVE, '1, '0, '0);
    send_request(FUNC_REMOVE, '1, '0, '0);
    send_request(FUNC_REMOVE, '1, '0, '0);
  endtask

  // Chain across the top of the table so the shift wraps to slot zero.
  task automatic test_wrapped_cluster();
    logic [KEY_W-1:0] k_top_a, k_top_b, k_zero, k_below;
    k_top_a = key_homed_in(SLOTS - 1, 1);
    k_top_b = key_homed_in(SLOTS - 1, 1);
    k_zero  = key_homed_in(0, 1);
    k_below = key_homed_in(SLOTS - 2, 1);
    send_request(FUNC_INSERT, k_top_a, rand64(), rand64());
    send_request(FUNC_INSERT, k_top_b, rand64(), rand64());
    send_request(FUNC_INSERT, k_zero, rand64(), rand64());
    send_request(FUNC_INSERT, k_below, rand64(), rand64());
    send_request(FUNC_REMOVE, k_top_a, rand64(), rand64());
    send_request(FUNC_REMOVE, k_below, rand64(), rand64());
    send_request(FUNC_REMOVE, k_zero, rand64(), rand64());
    send_request(FUNC_REMOVE, k_top_b, rand64(), rand64());
  endtask

  task automatic test_random_traffic();
    int               pick, src;
    bit               grow;
    logic [KEY_W-1:0] k;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_request(func_t'($urandom_range(0, 1)), '0, rand64(), rand64());
      end else if (pick < 8) begin
        send_request(FUNC_REMOVE, random_key(), rand64(), rand64());
      end else begin
        if (stored_keys.size() < 40)       grow = (pick < 80);
        else if (stored_keys.size() > 400) grow = (pick < 35);
        else                               grow = (pick < 55);
        if (grow || stored_keys.size() == 0) begin
          src = $urandom_range(0, 3);
          if (src == 0 && stored_keys.size() > 0)
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          else if (src == 1)
            k = key_homed_in($urandom_range(0, 2) == 0 ? SLOTS - 4 : 500, 8);
          else
            k = random_key();
          send_request(FUNC_INSERT, k, rand64(), rand64());
        end else begin
          k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          send_request(FUNC_REMOVE, k, rand64(), rand64());
        end
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_table();
    logic [KEY_W-1:0] k;
    no_idle = 1'b1;
    while (map_used < SLOTS) begin
      if ($urandom_range(0, 4) == 0 && stored_keys.size() > 0)
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else
        k = random_key();
      send_request(FUNC_INSERT, k, rand64(), rand64());
    end
    no_idle = 1'b0;
    send_request(FUNC_INSERT, random_key(), '1, '1);
    send_request(FUNC_INSERT, '0, rand64(), rand64());
    send_request(FUNC_REMOVE, random_key(), rand64(), rand64());
    repeat (4) begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      send_request(FUNC_REMOVE, k, rand64(), rand64());
      send_request(FUNC_INSERT, random_key(), rand64(), rand64());
    end
    send_request(FUNC_INSERT, '1, rand64(), rand64());
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      map_keys[s]  = '0;
      map_addrs[s] = '0;
      map_sizes[s] = '0;
    end
    map_used = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_invalid();
    test_duplicates();
    test_wrapped_cluster();
    test_random_traffic();
    test_full_table();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("linear_probe_hash_map_test: clean");
    end else begin
      $display("linear_probe_hash_map_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lph_pkg.sv
rtl/lph_hash.sv
rtl/linear_probe_hash_map.sv
test/linear_probe_hash_map_test.sv
